>>> hw/rtl/ccs_pkg.sv
`timescale 1ns / 1ps

package ccs_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned MAX_OUT  = 3;
    localparam int unsigned CNT_W    = 2;

    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    // Lexer mode; the skip modes discard to end of line and then fall back
    // to normal text or to a block comment.
    typedef enum logic [3:0] {
        MODE_NORMAL      = 4'b0001,
        MODE_BLOCK       = 4'b0010,
        MODE_SKIP_NORMAL = 4'b0100,
        MODE_SKIP_BLOCK  = 4'b1000
    } lex_mode_t;

    // All bytes that one input item produces, in output order.
    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [MAX_OUT-1:0][CHAR_W-1:0]   bytes;
    } ccs_entry_t;

endpackage

>>> hw/rtl/c_comment_stripper_unit.sv
`timescale 1ns / 1ps

// C comment stripper. Source text enters one byte per item on the s_ channel
// (s_valid, s_ready, s_char_in) and comment-free text leaves on the m_ channel
// (m_valid, m_ready, m_char_out, m_last_of_run). Each input byte yields zero
// to three output bytes; m_last_of_run marks the final byte of each run.
// Throughput is one input byte per cycle while the queue has room and one
// output byte per cycle while the receiver is ready. An accepted input byte
// is written into the queue, and its first output byte is then loaded into
// the output register. The front lexer classifies each byte combinationally
// and pushes its output run into a small queue of QUEUE_DEPTH runs; the
// back end serializes runs into the output register. When the receiver
// stalls, the queue fills and s_ready drops only once it holds QUEUE_DEPTH
// runs; bytes that produce nothing keep flowing while the queue has room.
// A synchronous active-low reset on aresetn puts the lexer at the start of a
// line in normal text and empties the queue and the output register.
module c_comment_stripper_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic       m_last_of_run
);

    // Runs travel from the lexer to the serializer through this queue.
    logic                q_push;
    ccs_pkg::ccs_entry_t q_entry;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    ccs_pkg::ccs_entry_t q_head;

    ccs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    ccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    ccs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_valid),
        .head_entry    (q_head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_out    (m_char_out),
        .m_last_of_run (m_last_of_run)
    );

    // A newline is always the final byte of its run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_char_out == ccs_pkg::CH_NL) |-> m_last_of_run)
        else $error("newline not marked as last of run");

    // The bytes of one run leave back to back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("gap inside an output run");

    // The input stalls only while the queue holds runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid)
        else $error("input stalled with an empty queue");

endmodule

>>> hw/rtl/ccs_front.sv
`timescale 1ns / 1ps

module ccs_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ccs_pkg::CHAR_W-1:0] s_char_in,
    input  logic                     q_full,
    output logic                     q_push,
    output ccs_pkg::ccs_entry_t      q_entry
);

    ccs_pkg::lex_mode_t mode_reg, mode_next;
    logic star_reg, star_next;
    logic slash_reg, slash_next;
    logic space_reg, space_next;
    logic leading_reg, leading_next;
    logic col0_reg, col0_next;

    logic accept;
    ccs_pkg::ccs_entry_t ent;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic sp;
        mode_next    = mode_reg;
        star_next    = star_reg;
        slash_next   = slash_reg;
        space_next   = space_reg;
        leading_next = leading_reg;
        col0_next    = col0_reg;
        ent          = '0;
        sp           = space_reg;

        if (s_char_in == ccs_pkg::CH_NL) begin
            if (mode_reg == ccs_pkg::MODE_NORMAL && slash_reg) begin
                if (space_reg) begin
                    ent.bytes[ent.count] = ccs_pkg::CH_SPACE;
                    ent.count = ent.count + 1'b1;
                end
                ent.bytes[ent.count] = ccs_pkg::CH_SLASH;
                ent.count = ent.count + 1'b1;
            end
            if (mode_reg == ccs_pkg::MODE_SKIP_NORMAL) begin
                mode_next = ccs_pkg::MODE_NORMAL;
            end else if (mode_reg == ccs_pkg::MODE_SKIP_BLOCK) begin
                mode_next = ccs_pkg::MODE_BLOCK;
            end
            ent.bytes[ent.count] = ccs_pkg::CH_NL;
            ent.count    = ent.count + 1'b1;
            slash_next   = 1'b0;
            space_next   = 1'b0;
            star_next    = 1'b0;
            leading_next = 1'b1;
            col0_next    = 1'b1;
        end else if (col0_reg && s_char_in == ccs_pkg::CH_HASH) begin
            col0_next    = 1'b0;
            leading_next = 1'b0;
            mode_next    = (mode_reg == ccs_pkg::MODE_BLOCK) ? ccs_pkg::MODE_SKIP_BLOCK
                                                             : ccs_pkg::MODE_SKIP_NORMAL;
        end else begin
            col0_next = 1'b0;
            if (mode_reg == ccs_pkg::MODE_SKIP_NORMAL || mode_reg == ccs_pkg::MODE_SKIP_BLOCK) begin
                // Rest of the line is discarded.
            end else if (leading_reg && s_char_in == ccs_pkg::CH_SPACE) begin
                // Indentation is dropped.
            end else begin
                leading_next = 1'b0;
                if (mode_reg == ccs_pkg::MODE_BLOCK) begin
                    if (star_reg && s_char_in == ccs_pkg::CH_SLASH) begin
                        mode_next = ccs_pkg::MODE_NORMAL;
                        star_next = 1'b0;
                    end else begin
                        star_next = (s_char_in == ccs_pkg::CH_STAR);
                    end
                end else if (slash_reg && s_char_in == ccs_pkg::CH_SLASH) begin
                    mode_next  = ccs_pkg::MODE_SKIP_NORMAL;
                    slash_next = 1'b0;
                    space_next = 1'b0;
                end else if (slash_reg && s_char_in == ccs_pkg::CH_STAR) begin
                    mode_next  = ccs_pkg::MODE_BLOCK;
                    star_next  = 1'b0;
                    slash_next = 1'b0;
                    space_next = 1'b0;
                end else begin
                    if (slash_reg) begin
                        if (sp) begin
                            ent.bytes[ent.count] = ccs_pkg::CH_SPACE;
                            ent.count = ent.count + 1'b1;
                        end
                        ent.bytes[ent.count] = ccs_pkg::CH_SLASH;
                        ent.count = ent.count + 1'b1;
                        sp         = 1'b0;
                        slash_next = 1'b0;
                    end
                    if (s_char_in == ccs_pkg::CH_SLASH) begin
                        slash_next = 1'b1;
                        space_next = sp;
                    end else if (s_char_in == ccs_pkg::CH_SPACE) begin
                        space_next = 1'b1;
                    end else begin
                        if (sp) begin
                            ent.bytes[ent.count] = ccs_pkg::CH_SPACE;
                            ent.count = ent.count + 1'b1;
                        end
                        space_next = 1'b0;
                        ent.bytes[ent.count] = s_char_in;
                        ent.count = ent.count + 1'b1;
                    end
                end
            end
        end
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.count != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= ccs_pkg::MODE_NORMAL;
            star_reg    <= 1'b0;
            slash_reg   <= 1'b0;
            space_reg   <= 1'b0;
            leading_reg <= 1'b1;
            col0_reg    <= 1'b1;
        end else if (accept) begin
            mode_reg    <= mode_next;
            star_reg    <= star_next;
            slash_reg   <= slash_next;
            space_reg   <= space_next;
            leading_reg <= leading_next;
            col0_reg    <= col0_next;
        end
    end

endmodule

>>> hw/rtl/ccs_queue.sv
`timescale 1ns / 1ps

module ccs_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ccs_pkg::ccs_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output ccs_pkg::ccs_entry_t head_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ccs_pkg::ccs_entry_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hw/rtl/ccs_back.sv
`timescale 1ns / 1ps

module ccs_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  ccs_pkg::ccs_entry_t        head_entry,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [ccs_pkg::CHAR_W-1:0] m_char_out,
    output logic                       m_last_of_run
);

    logic [ccs_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    logic [ccs_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                       last_reg, last_next;

    logic out_free, load, is_last;

    assign out_free = !valid_reg || m_ready;
    assign load     = out_free && head_valid;
    assign is_last  = (idx_reg == head_entry.count - 1'b1);
    assign pop      = load && is_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            char_next  = head_entry.bytes[idx_reg];
            last_next  = is_last;
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
        end else if (out_free) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_char_out    = char_reg;
    assign m_last_of_run = last_reg;

endmodule
